/* hdl/lad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lad_pkg
// Shared sizes, request and status codes, and controller states of the
// linear array deque.
// ----------------------------------------------------------------------------
package lad_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int DATA_W  = 32;
	localparam int REQ_W   = 3;
	localparam int STS_W   = 2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_REAR  = 3'd1,
		REQ_REM_FRONT = 3'd2,
		REQ_REM_REAR  = 3'd3,
		REQ_WALK      = 3'd4
	} req_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK     = 2'd0,
		STS_NOROOM = 2'd1,
		STS_EMPTY  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WALK
	} state_t;

endpackage

/* hdl/linear_array_deque.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_array_deque
// Double-ended queue in a linear, non-wrapping slot RAM with head and tail
// indices and an empty flag.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start / busy              req_type, value
//  result    strobe (one cycle)        status, data, last
//
//  An insert, or any request on an empty queue, is answered at once; its result
//  shows in the next cycle. A removal reads the slot RAM, whose read data is
//  registered, and passes that data on in the read state. A walk steps the
//  single RAM read port from head to tail, one result per element held.
//  Reset clears the indices and sets the empty flag; the slot RAM is not cleared.
//  The receiver cannot stall; a new request may be accepted in the cycle
//  the previous result is on the ports.
// ----------------------------------------------------------------------------
module linear_array_deque (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [lad_pkg::REQ_W-1:0]     req_type,
	input  logic signed [lad_pkg::DATA_W-1:0] value,
	output logic                          strobe,
	output logic [lad_pkg::STS_W-1:0]     status,
	output logic signed [lad_pkg::DATA_W-1:0] data,
	output logic                          last
);

	import lad_pkg::*;

	state_t  state_q, state_d;
	idx_t    head_q, head_d;
	idx_t    tail_q, tail_d;
	logic    empty_q, empty_d;
	idx_t    ptr_q, ptr_d;

	logic    accept;
	logic    wr_en, rd_en;
	idx_t    wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;

	logic    emit;
	status_t emit_status;
	logic [DATA_W-1:0] emit_data;
	logic    emit_last;

	logic    strobe_q;
	status_t status_q;
	logic [DATA_W-1:0] data_q;
	logic    last_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	lad_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !empty_q) begin
					case (req_type)
						REQ_REM_FRONT, REQ_REM_REAR: state_d = ST_READ;
						REQ_WALK:                    state_d = ST_WALK;
						default:                     state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_WALK: begin
				if (ptr_q == tail_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control and results
	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		empty_d     = empty_q;
		ptr_d       = ptr_q;
		wr_en       = 1'b0;
		wr_addr     = head_q;
		wr_data     = value;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		emit        = 1'b0;
		emit_status = STS_OK;
		emit_data   = '0;
		emit_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_INS_FRONT: begin
							emit = 1'b1;
							if (empty_q || head_q == '0) begin
								emit_status = STS_NOROOM;
							end else begin
								head_d  = head_q - idx_t'(1);
								wr_en   = 1'b1;
								wr_addr = head_q - idx_t'(1);
							end
						end
						REQ_INS_REAR: begin
							emit = 1'b1;
							if (empty_q) begin
								head_d  = '0;
								tail_d  = '0;
								empty_d = 1'b0;
								wr_en   = 1'b1;
								wr_addr = '0;
							end else if (tail_q == idx_t'(DEPTH - 1)) begin
								emit_status = STS_NOROOM;
							end else begin
								tail_d  = tail_q + idx_t'(1);
								wr_en   = 1'b1;
								wr_addr = tail_q + idx_t'(1);
							end
						end
						REQ_REM_FRONT, REQ_REM_REAR: begin
							if (empty_q) begin
								emit        = 1'b1;
								emit_status = STS_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = (req_type == REQ_REM_FRONT) ? head_q : tail_q;
								// drop the last element: both indices back to slot 0
								if (head_q == tail_q) begin
									head_d  = '0;
									tail_d  = '0;
									empty_d = 1'b1;
								end else if (req_type == REQ_REM_FRONT) begin
									head_d = head_q + idx_t'(1);
								end else begin
									tail_d = tail_q - idx_t'(1);
								end
							end
						end
						REQ_WALK: begin
							if (empty_q) begin
								emit        = 1'b1;
								emit_status = STS_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								ptr_d   = head_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				emit      = 1'b1;
				emit_data = rd_data;
			end
			ST_WALK: begin
				emit      = 1'b1;
				emit_data = rd_data;
				emit_last = (ptr_q == tail_q);
				// advance to the next slot while not at the tail
				if (ptr_q != tail_q) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + idx_t'(1);
					ptr_d   = ptr_q + idx_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			empty_q  <= empty_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (emit) begin
			status_q <= emit_status;
			data_q   <= emit_data;
			last_q   <= emit_last;
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign data   = signed'(data_q);
	assign last   = last_q;

endmodule

/* hdl/lad_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lad_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
